>>> rtl/mfdt_pkg.sv
// Shared types and constants for the Mersenne-form divisor test block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package mfdt_pkg;

  localparam int FIELD_W   = 64;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [FIELD_W-1:0] EXP_RESET  = 64'd136279841;
  localparam logic [FIELD_W-1:0] MULT_RESET = 64'd28;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_NO_HIT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HIT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_P_ZERO = 2'd2;
  localparam logic [STATUS_W-1:0] ST_Q_ZERO = 2'd3;

  // operand selection for the shared modular multiplier
  localparam logic [1:0] OP_ACC_SQ = 2'd0;
  localparam logic [1:0] OP_SQ_SQ  = 2'd1;
  localparam logic [1:0] OP_Q_K    = 2'd2;

  typedef struct packed {
    logic                load;
    logic                mul_start;
    logic [1:0]          mul_op;
    logic                acc_wr;
    logic                sq_wr;
    logic                e_shift;
    logic                st_wr;
    logic [STATUS_W-1:0] st_code;
    logic                out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic n_small;
    logic e_zero;
    logic e_lsb;
    logic p_zero;
    logic p_one;
    logic mul_busy;
    logic mul_done;
    logic hit;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/mfdt_if.sv
// Valid/ready channel interfaces for the candidate input and the test result.
// Depends on mfdt_pkg.
`timescale 1ns / 1ps

interface mfdt_in_if;
  import mfdt_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface mfdt_out_if;
  import mfdt_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIELD_W-1:0]  power_residue;

  modport source (output valid, output status, output power_residue, input ready);
  modport sink   (input valid, input status, input power_residue, output ready);
endinterface

>>> rtl/mfdt_mulmod.sv
// Bit-serial modular multiplier: x*y mod n, one bit of y per cycle, MSB first.
// Needs x < n; y may be any value (reduced on the fly). Depends on mfdt_pkg.
`timescale 1ns / 1ps

module mfdt_mulmod #(
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] x,
  input  logic [DW-1:0] y,
  input  logic [DW-1:0] n,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] res
);
  import mfdt_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] acc_r, y_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW+1:0] t, d1, d2, n1, n2;
  logic [DW-1:0] acc_nxt;

  // 2*acc + bit*x is below 3n, so one of three candidates is the residue
  always_comb begin
    n1 = {2'b00, n};
    n2 = {1'b0, n, 1'b0};
    t  = {1'b0, acc_r, 1'b0} + {2'b00, (y_r[DW-1] ? x : {DW{1'b0}})};
    d1 = t - n1;
    d2 = t - n2;
    if (t >= n2) begin
      acc_nxt = d2[DW-1:0];
    end else if (t >= n1) begin
      acc_nxt = d1[DW-1:0];
    end else begin
      acc_nxt = t[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      y_r   <= y;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      y_r   <= {y_r[DW-2:0], 1'b0};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res  = acc_r;

`ifndef SYNTH
  a_res_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && (n != '0)) |-> (acc_r < n))
    else $error("mulmod result not reduced");
`endif

endmodule

>>> rtl/mfdt_dp.sv
// Datapath: configuration registers, modulus, exponent shifter, power and
// square registers, the shared modular multiplier and the result register.
// Depends on mfdt_pkg and mfdt_mulmod.
`timescale 1ns / 1ps

module mfdt_dp #(
  parameter int DW = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mfdt_pkg::dp_cmd_t                cmd,
  output mfdt_pkg::dp_sts_t                sts,
  input  logic                             cfg_we,
  input  logic [mfdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mfdt_pkg::FIELD_W-1:0]     cfg_data,
  input  logic [mfdt_pkg::FIELD_W-1:0]     in_candidate,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [mfdt_pkg::STATUS_W-1:0]    out_status,
  output logic [mfdt_pkg::FIELD_W-1:0]     out_power_residue
);
  import mfdt_pkg::*;

  logic [FIELD_W-1:0]  exp_cfg_r, mult_cfg_r, e_r;
  logic [DW-1:0]       n_r, acc_r, sq_r, in_n;
  logic [STATUS_W-1:0] status_r, out_status_r;
  logic [FIELD_W-1:0]  out_res_r;
  logic                out_valid_r;
  logic [DW-1:0]       mul_x, mul_y, mul_res;
  logic                mul_busy, mul_done;

  assign in_n = in_candidate[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cfg_r  <= EXP_RESET;
      mult_cfg_r <= MULT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_EXPONENT) begin
        exp_cfg_r <= cfg_data;
      end else begin
        mult_cfg_r <= cfg_data;
      end
    end
  end

  always_comb begin
    case (cmd.mul_op)
      OP_ACC_SQ: begin
        mul_x = acc_r;
        mul_y = sq_r;
      end
      OP_Q_K: begin
        mul_x = acc_r - DW'(1);
        mul_y = mult_cfg_r[DW-1:0];
      end
      default: begin
        mul_x = sq_r;
        mul_y = sq_r;
      end
    endcase
  end

  mfdt_mulmod #(.DW(DW)) u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .n     (n_r),
    .busy  (mul_busy),
    .done  (mul_done),
    .res   (mul_res)
  );

  // 1 mod n and 2 mod n seeds; n of 0 or 1 skips the loop with power 0
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r   <= in_n;
      e_r   <= exp_cfg_r;
      acc_r <= (in_n[DW-1:1] == '0) ? DW'(0) : DW'(1);
      sq_r  <= (in_n < DW'(3)) ? DW'(0) : DW'(2);
    end else begin
      if (cmd.acc_wr) begin
        acc_r <= mul_res;
      end
      if (cmd.sq_wr) begin
        sq_r <= mul_res;
      end
      if (cmd.e_shift) begin
        e_r <= {1'b0, e_r[FIELD_W-1:1]};
      end
    end
    if (cmd.st_wr) begin
      status_r <= cmd.st_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_res_r    <= FIELD_W'(acc_r);
    end
  end

  always_comb begin
    sts          = '0;
    sts.n_small  = (n_r[DW-1:1] == '0);
    sts.e_zero   = (e_r == '0);
    sts.e_lsb    = e_r[0];
    sts.p_zero   = (acc_r == '0);
    sts.p_one    = (acc_r == DW'(1));
    sts.mul_busy = mul_busy;
    sts.mul_done = mul_done;
    sts.hit      = (mul_res == n_r - DW'(1));
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_power_residue = out_res_r;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transaction");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !mul_busy)
    else $error("new candidate loaded while multiplier busy");
`endif

endmodule

>>> rtl/mfdt_ctrl.sv
// Controller FSM: walks the exponent bits, sequences the shared multiplier
// and the final hit test, then hands the result to the output register.
// Depends on mfdt_pkg.
`timescale 1ns / 1ps

module mfdt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output mfdt_pkg::dp_cmd_t cmd,
  input  mfdt_pkg::dp_sts_t sts
);
  import mfdt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STEP  = 3'd1;
  localparam logic [2:0] S_MUL_A = 3'd2;
  localparam logic [2:0] S_MUL_S = 3'd3;
  localparam logic [2:0] S_TEST  = 3'd4;
  localparam logic [2:0] S_MUL_K = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (sts.n_small || sts.e_zero) begin
          state_nxt = S_TEST;
        end else if (sts.e_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = OP_ACC_SQ;
          state_nxt     = S_MUL_A;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = OP_SQ_SQ;
          state_nxt     = S_MUL_S;
        end
      end
      S_MUL_A: begin
        cmd.mul_op = OP_ACC_SQ;
        if (sts.mul_done) begin
          cmd.acc_wr    = 1'b1;
          cmd.mul_start = 1'b1;
          cmd.mul_op    = OP_SQ_SQ;
          state_nxt     = S_MUL_S;
        end
      end
      S_MUL_S: begin
        cmd.mul_op = OP_SQ_SQ;
        if (sts.mul_done) begin
          cmd.sq_wr   = 1'b1;
          cmd.e_shift = 1'b1;
          state_nxt   = S_STEP;
        end
      end
      S_TEST: begin
        if (sts.p_zero) begin
          cmd.st_wr   = 1'b1;
          cmd.st_code = ST_P_ZERO;
          state_nxt   = S_FIN;
        end else if (sts.p_one) begin
          cmd.st_wr   = 1'b1;
          cmd.st_code = ST_Q_ZERO;
          state_nxt   = S_FIN;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = OP_Q_K;
          state_nxt     = S_MUL_K;
        end
      end
      S_MUL_K: begin
        cmd.mul_op = OP_Q_K;
        if (sts.mul_done) begin
          cmd.st_wr   = 1'b1;
          cmd.st_code = sts.hit ? ST_HIT : ST_NO_HIT;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mul_done |-> (state_r == S_MUL_A || state_r == S_MUL_S || state_r == S_MUL_K))
    else $error("multiplier finished outside a multiply state");
  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_start && sts.mul_busy) |-> 1'b0)
    else $error("multiplier restarted while busy");
`endif

endmodule

>>> rtl/mersenne_form_divisor_test.sv
// Tests whether candidate n divides k*(2^e - 1) + 1: computes p = 2^e mod n by
// right-to-left square and multiply, then checks k*(p-1) == -1 mod n. One
// candidate is worked at a time on a single bit-serial modular multiplier; each
// exponent bit up to the highest set one costs one or two products, and the
// final test one more product. n of 0 or 1 skips the exponent loop. A new
// candidate is taken once the previous one has reached the result register,
// even if that result has not yet been taken. Configuration (exponent at
// index 0, multiplier at index 1) may be written only when idle.
`timescale 1ns / 1ps

module mersenne_form_divisor_test #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mfdt_in_if.sink                        in_ch,
  mfdt_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [mfdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mfdt_pkg::FIELD_W-1:0]   cfg_data
);
  import mfdt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mfdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mfdt_dp #(.DW(DATA_WIDTH)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_candidate      (in_ch.candidate),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_status        (out_ch.status),
    .out_power_residue (out_ch.power_residue)
  );

endmodule
